FILE: sv/length_prefixed_message_fifo_top_defines.svh
// assertion macros for the length-prefixed message fifo
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define LPMF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define LPMF_NEVER(label, cond, msg) \
	`LPMF_ASSERT(label, !(cond), msg)

`endif

FILE: sv/lpmf_pkg.sv
// shared constants, codes and control types of the message fifo
package lpmf_pkg;

	localparam int CAPACITY    = 4096;
	localparam int MAX_MESSAGE = 255;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int PTR_W       = ADDR_W + 1;
	localparam int SUM_W       = ((PTR_W > 9) ? PTR_W : 9) + 1;

	typedef enum logic [2:0] {
		ST_STORED    = 3'd0,
		ST_COMMITTED = 3'd1,
		ST_DISCARDED = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_DELIVERED = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_EXEC    = 5'b00010,
		S_PUSH    = 5'b00100,
		S_POP_LEN = 5'b01000,
		S_POP_OUT = 5'b10000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic len_wr;
		logic rd_len;
		logic push_upd;
		logic rd_byte;
		logic pop_out;
	} cmd_t;

	typedef struct packed {
		logic is_push;
		logic empty;
		logic first_accept;
		logic out_free;
	} sts_t;

endpackage

FILE: sv/lpmf_ctrl.sv
// controller state machine sequencing push and pop operations
module lpmf_ctrl import lpmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (sts.is_push) begin
					cmd.len_wr = sts.first_accept;
					state_d    = S_PUSH;
				end else if (sts.empty) begin
					state_d = S_POP_OUT;
				end else begin
					cmd.rd_len = 1'b1;
					state_d    = S_POP_LEN;
				end
			end
			S_PUSH: begin
				cmd.push_upd = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_POP_LEN: begin
				cmd.rd_byte = 1'b1;
				state_d     = S_POP_OUT;
			end
			S_POP_OUT: begin
				cmd.pop_out = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/lpmf_datapath.sv
// ring memory, pointers, push/pop bookkeeping and the output register
module lpmf_datapath import lpmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] s_tdata,
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	logic [7:0] ring_q [CAPACITY];
	logic [7:0] rdata_q;

	// latched request
	logic       req_q;
	logic [7:0] data_q;
	logic [7:0] len_q;

	logic [PTR_W-1:0] wp_q, rp_q;
	logic [7:0]       push_off_q, push_rem_q, pop_off_q;
	logic             drop_q;
	logic [7:0]       mlen_q;

	logic [23:0] tdata_q;
	logic [2:0]  tuser_q;
	logic        tlast_q, tvalid_q;

	// push decision
	logic             first, zero_len, too_long, no_room, first_accept, store_byte;
	logic [PTR_W-1:0] used;
	logic [SUM_W-1:0] need;
	logic [7:0]       len_m1, new_off, new_rem;
	logic [7:0]       push_off_n, push_rem_n;
	logic             drop_n;
	logic [PTR_W-1:0] wp_n;
	status_t          push_st;
	logic [PTR_W-1:0] push_addr, pop_addr;
	logic             pop_last;

	assign used         = wp_q - rp_q;
	assign need         = SUM_W'(used) + SUM_W'(len_q) + SUM_W'(1);
	assign first        = (push_rem_q == 8'd0);
	assign zero_len     = (len_q == 8'd0);
	assign too_long     = (len_q > 8'(MAX_MESSAGE));
	assign no_room      = (need > SUM_W'(CAPACITY));
	assign first_accept = first && !zero_len && !too_long && !no_room;
	assign store_byte   = first ? first_accept : !drop_q;
	assign len_m1       = len_q - 8'd1;
	assign new_off      = push_off_q + 8'd1;
	assign new_rem      = first ? len_m1 : (push_rem_q - 8'd1);
	assign push_addr    = wp_q + PTR_W'(1) + PTR_W'(push_off_q);
	assign pop_addr     = rp_q + PTR_W'(1) + PTR_W'(pop_off_q);
	assign pop_last     = ({1'b0, pop_off_q} + 9'd1) >= {1'b0, mlen_q};

	always_comb begin
		push_off_n = push_off_q;
		push_rem_n = push_rem_q;
		drop_n     = drop_q;
		wp_n       = wp_q;
		push_st    = ST_DISCARDED;
		priority if (first && zero_len) begin
			push_st = ST_DISCARDED;
		end else if (first && !first_accept) begin
			// whole message dropped, swallow its remaining bytes
			push_rem_n = len_m1;
			drop_n     = (len_m1 != 8'd0);
			push_off_n = 8'd0;
			push_st    = ST_DISCARDED;
		end else if (!first && drop_q) begin
			push_rem_n = push_rem_q - 8'd1;
			drop_n     = (push_rem_q != 8'd1);
			push_st    = ST_DISCARDED;
		end else begin
			drop_n     = 1'b0;
			push_rem_n = new_rem;
			if (new_rem == 8'd0) begin
				wp_n       = wp_q + PTR_W'(new_off) + PTR_W'(1);
				push_off_n = 8'd0;
				push_st    = ST_COMMITTED;
			end else begin
				push_off_n = new_off;
				push_st    = ST_STORED;
			end
		end
	end

	assign sts.is_push      = (req_q == 1'b0);
	assign sts.empty        = (rp_q == wp_q);
	assign sts.first_accept = first_accept;
	assign sts.out_free     = !tvalid_q || m_tready;

	// single-port ring, registered read
	always_ff @(posedge clk) begin
		if (cmd.len_wr) begin
			ring_q[wp_q[ADDR_W-1:0]] <= len_q;
		end else if (cmd.push_upd && store_byte) begin
			ring_q[push_addr[ADDR_W-1:0]] <= data_q;
		end else if (cmd.rd_len) begin
			rdata_q <= ring_q[rp_q[ADDR_W-1:0]];
		end else if (cmd.rd_byte) begin
			rdata_q <= ring_q[pop_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q  <= s_tuser[0];
			data_q <= s_tdata[7:0];
			len_q  <= s_tdata[15:8];
		end
		if (cmd.rd_byte) begin
			mlen_q <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			push_off_q <= '0;
			push_rem_q <= '0;
			drop_q     <= 1'b0;
			pop_off_q  <= '0;
		end else begin
			if (cmd.push_upd) begin
				wp_q       <= wp_n;
				push_off_q <= push_off_n;
				push_rem_q <= push_rem_n;
				drop_q     <= drop_n;
			end
			if (cmd.pop_out && !sts.empty) begin
				if (pop_last) begin
					rp_q      <= rp_q + PTR_W'(mlen_q) + PTR_W'(1);
					pop_off_q <= 8'd0;
				end else begin
					pop_off_q <= pop_off_q + 8'd1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (cmd.push_upd || cmd.pop_out) begin
			tvalid_q <= 1'b1;
		end else if (m_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_upd) begin
			tuser_q <= push_st;
			tdata_q <= '0;
			tlast_q <= 1'b0;
		end else if (cmd.pop_out) begin
			if (sts.empty) begin
				tuser_q <= ST_EMPTY;
				tdata_q <= '0;
				tlast_q <= 1'b0;
			end else begin
				tuser_q <= ST_DELIVERED;
				tdata_q <= {7'd0, mlen_q, (pop_off_q == 8'd0), rdata_q};
				tlast_q <= pop_last;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

endmodule

FILE: sv/length_prefixed_message_fifo_top.sv
// top level of the length-prefixed message fifo
//
//  channel  dir  tdata                              tuser          tlast
//  s_*      in   [7:0] data_byte, [15:8] msg_len    [0] req_type   -
//  m_*      out  [7:0] out_byte, [8] out_first,     [2:0] status   out_last
//                [16:9] out_len, [23:17] zero
//
// one transfer in, one result out; a push steps through accept, exec and push, a pop through accept,
// exec, length read and output (no length read on empty), set by the single port of the ring memory
// (a first push byte writes two entries, a pop reads the length entry and then the payload entry)
// a held result stalls the next item only at its result step, not its accept
// reset clears pointers and counters; ring contents are never cleared
`include "length_prefixed_message_fifo_top_defines.svh"

module length_prefixed_message_fifo_top import lpmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] data_byte, [15:8] msg_len
	input  logic [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [8] out_first, [16:9] out_len
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);

	cmd_t cmd;
	sts_t sts;

	lpmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpmf_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`LPMF_ASSERT(a_one_item_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
	`LPMF_NEVER(a_no_result_overwrite, (cmd.push_upd || cmd.pop_out) && m_tvalid && !m_tready, "result overwritten")
	`LPMF_NEVER(a_single_mem_access, (cmd.len_wr || cmd.push_upd) && (cmd.rd_len || cmd.rd_byte), "memory port conflict")
	`LPMF_ASSERT(a_result_has_source, $rose(m_tvalid) |-> ($past(cmd.push_upd) || $past(cmd.pop_out)), "result from nowhere")

endmodule

FILE: sim/length_prefixed_message_fifo_top_tb.sv
// self-checking testbench for the length-prefixed message fifo top level
`timescale 1ns / 1ps

module length_prefixed_message_fifo_top_tb;
	import lpmf_pkg::*;

	localparam bit REQ_PUSH = 1'b0;
	localparam bit REQ_POP  = 1'b1;
	localparam int MAX_MISMATCH_SHOWN = 10;

	typedef struct {
		status_t    status;
		logic [7:0] data;
		logic       first;
		logic       last;
		logic [7:0] len;
	} fifo_resp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] data_byte, [15:8] msg_len
	logic [0:0]  s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // [7:0] out_byte, [8] out_first, [16:9] out_len
	logic [2:0]  m_tuser;   // [2:0] status
	logic        m_tlast;

	// shadow of the block state
	logic [7:0]       shadow_ring [CAPACITY];
	logic [PTR_W-1:0] shadow_wr;
	logic [PTR_W-1:0] shadow_rd;
	int unsigned      open_written;
	int unsigned      open_left;
	bit               open_dropping;
	int unsigned      pop_pos;

	fifo_resp_t  response_q [$];
	int unsigned mismatch_count = 0;
	bit          gaps_enabled = 1'b1;
	int unsigned stall_left = 0;

	length_prefixed_message_fifo_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int unsigned ring_used();
		logic [PTR_W-1:0] diff;
		diff = shadow_wr - shadow_rd;
		return 32'(diff);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// computes the response to one accepted transfer and updates the shadow state
	task automatic predict_fifo_response(input bit req, input logic [7:0] data,
			input logic [7:0] len);
		fifo_resp_t       r;
		logic [ADDR_W-1:0] idx;
		int unsigned      mlen;
		bit               wrote;
		r = '{ST_STORED, 8'd0, 1'b0, 1'b0, 8'd0};
		wrote = 1'b0;
		if (req == REQ_PUSH) begin
			if (open_left == 0) begin
				if (len == 0) begin
					r.status = ST_DISCARDED;
				end else if (len > MAX_MESSAGE || ring_used() + len + 1 > CAPACITY) begin
					open_left = len - 1;
					open_dropping = (open_left != 0);
					open_written = 0;
					r.status = ST_DISCARDED;
				end else begin
					idx = shadow_wr[ADDR_W-1:0];
					shadow_ring[idx] = len;
					idx = ADDR_W'(shadow_wr + 1);
					shadow_ring[idx] = data;
					open_dropping = 1'b0;
					open_written = 1;
					open_left = len - 1;
					wrote = 1'b1;
				end
			end else if (open_dropping) begin
				open_left--;
				if (open_left == 0)
					open_dropping = 1'b0;
				r.status = ST_DISCARDED;
			end else begin
				idx = ADDR_W'(shadow_wr + 1 + open_written);
				shadow_ring[idx] = data;
				open_written++;
				open_left--;
				wrote = 1'b1;
			end
			if (wrote) begin
				if (open_left == 0) begin
					shadow_wr = PTR_W'(shadow_wr + open_written + 1);
					open_written = 0;
					r.status = ST_COMMITTED;
				end else begin
					r.status = ST_STORED;
				end
			end
		end else if (shadow_rd == shadow_wr) begin
			r.status = ST_EMPTY;
		end else begin
			idx = shadow_rd[ADDR_W-1:0];
			mlen = 32'(shadow_ring[idx]);
			idx = ADDR_W'(shadow_rd + 1 + pop_pos);
			r.status = ST_DELIVERED;
			r.data = shadow_ring[idx];
			r.first = (pop_pos == 0);
			r.last = (pop_pos + 1 >= mlen);
			r.len = 8'(mlen);
			if (r.last) begin
				shadow_rd = PTR_W'(shadow_rd + mlen + 1);
				pop_pos = 0;
			end else begin
				pop_pos++;
			end
		end
		response_q.insert(response_q.size(), r);
	endtask

	task automatic send_item(input bit req, input logic [7:0] data, input logic [7:0] len);
		@(negedge clk);
		if (gaps_enabled && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {len, data};
		s_tuser = req;
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_fifo_response(req, data, len);
	endtask

	// msg_len on continuation bytes is random, the block must ignore it
	task automatic push_message(input int unsigned len);
		for (int k = 0; k < len; k++)
			send_item(REQ_PUSH, rand_byte(), (k == 0) ? 8'(len) : rand_byte());
	endtask

	task automatic drain_ring();
		while (shadow_rd != shadow_wr)
			send_item(REQ_POP, rand_byte(), rand_byte());
	endtask

	task automatic test_directed();
		send_item(REQ_POP, 8'hff, 8'hff);    // pop on empty ring
		send_item(REQ_PUSH, 8'hff, 8'd0);    // zero length is discarded
		send_item(REQ_PUSH, 8'h00, 8'd1);    // single byte message commits at once
		send_item(REQ_POP, 8'h00, 8'h00);
		send_item(REQ_POP, 8'h00, 8'h00);
		send_item(REQ_PUSH, 8'hff, 8'd3);
		send_item(REQ_POP, 8'h5a, 8'h00);    // open message is not visible yet
		send_item(REQ_PUSH, 8'ha5, 8'd0);
		send_item(REQ_PUSH, 8'h5a, 8'hff);
		send_item(REQ_PUSH, 8'h00, 8'd2);
		send_item(REQ_POP, 8'h00, 8'h00);
		send_item(REQ_PUSH, 8'hff, 8'd1);
		send_item(REQ_POP, 8'hff, 8'hff);
		send_item(REQ_POP, 8'hff, 8'hff);
		send_item(REQ_POP, 8'h00, 8'h00);
		send_item(REQ_POP, 8'h00, 8'h00);
		send_item(REQ_POP, 8'h00, 8'h00);
	endtask

	task automatic test_long_messages();
		drain_ring();
		push_message(MAX_MESSAGE);
		// pops between the bytes of an open message see only committed ones
		for (int k = 0; k < 100; k++) begin
			send_item(REQ_PUSH, rand_byte(), (k == 0) ? 8'd100 : rand_byte());
			send_item(REQ_POP, rand_byte(), rand_byte());
		end
		drain_ring();
	endtask

	task automatic run_random_traffic(input int unsigned count, input bit with_gaps);
		int unsigned pop_pct;
		int unsigned pick;
		int unsigned len;
		gaps_enabled = with_gaps;
		pop_pct = 50;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 200 == 0)
				pop_pct = $urandom_range(20, 70);
			if ($urandom_range(0, 99) < pop_pct) begin
				send_item(REQ_POP, rand_byte(), rand_byte());
			end else if (open_left != 0) begin
				send_item(REQ_PUSH, rand_byte(), rand_byte());
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					len = 0;
				else if (pick < 85)
					len = $urandom_range(1, 16);
				else if (pick < 97)
					len = $urandom_range(17, 64);
				else
					len = $urandom_range(65, 255);
				send_item(REQ_PUSH, rand_byte(), 8'(len));
			end
		end
	endtask

	// receiver side: random stall bursts while gaps are enabled
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready = 1'b0;
		end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		fifo_resp_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (response_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_MISMATCH_SHOWN)
					$display("unexpected result at %0t: status %0d byte %02h",
						$time, m_tuser, m_tdata[7:0]);
			end else begin
				exp_r = response_q.pop_front();
				if (m_tuser !== exp_r.status || m_tdata[7:0] !== exp_r.data ||
						m_tdata[8] !== exp_r.first || m_tlast !== exp_r.last ||
						m_tdata[16:9] !== exp_r.len) begin
					mismatch_count++;
					if (mismatch_count <= MAX_MISMATCH_SHOWN)
						$display("mismatch %0t exp/got st %0d/%0d byte %h/%h first %b/%b last %b/%b len %0d/%0d",
							$time, exp_r.status, m_tuser, exp_r.data, m_tdata[7:0],
							exp_r.first, m_tdata[8], exp_r.last, m_tlast,
							exp_r.len, m_tdata[16:9]);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		shadow_wr = '0;
		shadow_rd = '0;
		open_written = 0;
		open_left = 0;
		open_dropping = 1'b0;
		pop_pos = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_long_messages();
		run_random_traffic(750, 1'b1);
		run_random_traffic(200, 1'b0);

		@(negedge clk);
		s_tvalid = 1'b0;
		while (response_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/lpmf_pkg.sv
sv/lpmf_ctrl.sv
sv/lpmf_datapath.sv
sv/length_prefixed_message_fifo_top.sv
sim/length_prefixed_message_fifo_top_tb.sv
